### sv/tfc_pkg.sv
// shared types and constants for the telemetry frame checker
package tfc_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] StartByteReset = 8'd153;
  localparam logic [ByteW-1:0] MsgHeaderLen   = 8'd4;
  localparam logic [ByteW-1:0] MsgTailLen     = 8'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_payload;
    logic             frame_end;
    logic             frame_good;
    logic [ByteW-1:0] sender_id;
    logic [ByteW-1:0] message_id;
  } result_t;

endpackage

### sv/tfc_byte_if.sv
// valid/ready channel carrying one received byte per transaction
interface tfc_byte_if;
  logic                        valid;
  logic                        ready;
  logic [tfc_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/tfc_result_if.sv
// valid/ready channel carrying one checked byte and its frame status per transaction
interface tfc_result_if;
  logic                        valid;
  logic                        ready;
  logic [tfc_pkg::ByteW-1:0]   data_byte;
  logic                        is_payload;
  logic                        frame_end;
  logic                        frame_good;
  logic [tfc_pkg::ByteW-1:0]   sender_id;
  logic [tfc_pkg::ByteW-1:0]   message_id;

  modport source (output valid, output data_byte, output is_payload, output frame_end,
                  output frame_good, output sender_id, output message_id, input ready);
  modport sink   (input valid, input data_byte, input is_payload, input frame_end,
                  input frame_good, input sender_id, input message_id, output ready);
endinterface

### sv/tfc_deframer.sv
// frame state machine with running fletcher sums and check byte compare
module tfc_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [tfc_pkg::ByteW-1:0] byte_i,
  input  logic [tfc_pkg::ByteW-1:0] start_byte_i,
  output tfc_pkg::result_t          res_o
);

  tfc_pkg::phase_e           phase_q, phase_d;
  logic [tfc_pkg::ByteW-1:0] len_q, len_d;
  logic [tfc_pkg::ByteW-1:0] pos_q, pos_d;
  logic [tfc_pkg::ByteW-1:0] sum1_q, sum1_d;
  logic [tfc_pkg::ByteW-1:0] sum2_q, sum2_d;
  logic [tfc_pkg::ByteW-1:0] chk1_q, chk1_d;
  logic [tfc_pkg::ByteW-1:0] sender_q, sender_d;
  logic [tfc_pkg::ByteW-1:0] message_q, message_d;

  logic [tfc_pkg::ByteW:0]   pos_ext;
  logic [tfc_pkg::ByteW:0]   len_ext;
  logic                      in_sum;
  logic                      at_chk1;
  logic [tfc_pkg::ByteW-1:0] sum1_add;

  assign pos_ext  = {1'b0, pos_q};
  assign len_ext  = {1'b0, len_q};
  assign in_sum   = (pos_ext + {1'b0, tfc_pkg::MsgTailLen} + 9'd1) <= len_ext;
  assign at_chk1  = (pos_ext + {1'b0, tfc_pkg::MsgTailLen}) == len_ext;
  assign sum1_add = sum1_q + byte_i;

  // next state
  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    pos_d     = pos_q;
    sum1_d    = sum1_q;
    sum2_d    = sum2_q;
    chk1_d    = chk1_q;
    sender_d  = sender_q;
    message_d = message_q;
    unique case (phase_q)
      tfc_pkg::PH_HUNT: begin
        if (byte_i == start_byte_i) begin
          phase_d   = tfc_pkg::PH_LEN;
          pos_d     = 8'd1;
          sum1_d    = '0;
          sum2_d    = '0;
          chk1_d    = '0;
          sender_d  = '0;
          message_d = '0;
        end
      end
      tfc_pkg::PH_LEN: begin
        if (byte_i < tfc_pkg::MsgHeaderLen) begin
          phase_d = tfc_pkg::PH_HUNT;
        end else begin
          len_d   = byte_i;
          sum1_d  = byte_i;
          sum2_d  = byte_i;
          pos_d   = 8'd2;
          phase_d = tfc_pkg::PH_BODY;
        end
      end
      tfc_pkg::PH_BODY: begin
        if (pos_q == 8'd2) begin
          sender_d = byte_i;
        end
        if (pos_q == 8'd3) begin
          message_d = byte_i;
        end
        if (in_sum) begin
          sum1_d = sum1_add;
          sum2_d = sum2_q + sum1_add;
        end else if (at_chk1) begin
          chk1_d = byte_i;
        end else begin
          phase_d = tfc_pkg::PH_HUNT;
        end
        pos_d = pos_q + 8'd1;
      end
      default: begin
        phase_d = tfc_pkg::PH_HUNT;
      end
    endcase
  end

  // result fields
  always_comb begin
    res_o            = '0;
    res_o.data_byte  = byte_i;
    res_o.sender_id  = sender_d;
    res_o.message_id = message_d;
    unique case (phase_q)
      tfc_pkg::PH_HUNT: begin
      end
      tfc_pkg::PH_LEN: begin
        res_o.frame_end = byte_i < tfc_pkg::MsgHeaderLen;
      end
      tfc_pkg::PH_BODY: begin
        if (in_sum) begin
          res_o.is_payload = pos_q >= tfc_pkg::MsgHeaderLen;
        end else if (!at_chk1) begin
          res_o.frame_end  = 1'b1;
          res_o.frame_good = (chk1_q == sum1_q) && (byte_i == sum2_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tfc_pkg::PH_HUNT;
      len_q     <= '0;
      pos_q     <= '0;
      sum1_q    <= '0;
      sum2_q    <= '0;
      chk1_q    <= '0;
      sender_q  <= '0;
      message_q <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      sum1_q    <= sum1_d;
      sum2_q    <= sum2_d;
      chk1_q    <= chk1_d;
      sender_q  <= sender_d;
      message_q <= message_d;
    end
  end

endmodule

### sv/telemetry_frame_checker_top.sv
// telemetry frame checker top level: input register, deframer, result register
// path: each byte passes the input register, then the deframer, then the result register
// throughput: one byte per cycle, limited only by the result channel backpressure
// the input register and the result register each hold one byte in flight
// reset: async active low; hunts for the start byte, start byte set to 153, ids zero
module telemetry_frame_checker_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tfc_pkg::ByteW-1:0] cfg_wdata_i,
  tfc_byte_if.sink                  in_i,
  tfc_result_if.source              out_o
);

  logic [tfc_pkg::ByteW-1:0] start_q;
  logic                      in_valid_q;
  logic [tfc_pkg::ByteW-1:0] in_byte_q;
  logic                      out_valid_q;
  tfc_pkg::result_t          out_q;
  tfc_pkg::result_t          res;
  logic                      advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= tfc_pkg::StartByteReset;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.rx_byte;
    end
  end

  tfc_deframer u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .byte_i       (in_byte_q),
    .start_byte_i (start_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_byte  = out_q.data_byte;
  assign out_o.is_payload = out_q.is_payload;
  assign out_o.frame_end  = out_q.frame_end;
  assign out_o.frame_good = out_q.frame_good;
  assign out_o.sender_id  = out_q.sender_id;
  assign out_o.message_id = out_q.message_id;

endmodule

### tb/tfc_frame_scoreboard.sv
// checker for the telemetry frame checker: predicts each transaction and compares results
`timescale 1ns / 1ps

module tfc_frame_scoreboard
  import tfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  tfc_byte_if              byte_mon,
  tfc_result_if            res_mon,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  phase_e           hunt_phase;
  logic [ByteW-1:0] start_val;
  logic [ByteW-1:0] frame_len;
  logic [ByteW-1:0] byte_pos;
  logic [ByteW-1:0] fsum_a;
  logic [ByteW-1:0] fsum_b;
  logic [ByteW-1:0] first_check;
  logic [ByteW-1:0] sender_q;
  logic [ByteW-1:0] message_q;

  result_t deframed_q [$];

  function automatic result_t deframe_byte(input logic [ByteW-1:0] b);
    result_t     r;
    int unsigned p;
    int unsigned len;
    r = '0;
    r.data_byte = b;
    case (hunt_phase)
      PH_HUNT: begin
        if (b == start_val) begin
          hunt_phase  = PH_LEN;
          byte_pos    = 8'd1;
          fsum_a      = '0;
          fsum_b      = '0;
          first_check = '0;
          sender_q    = '0;
          message_q   = '0;
        end
      end
      PH_LEN: begin
        if (b < MsgHeaderLen) begin
          r.frame_end = 1'b1;
          hunt_phase  = PH_HUNT;
        end else begin
          frame_len  = b;
          fsum_a     = b;
          fsum_b     = b;
          byte_pos   = 8'd2;
          hunt_phase = PH_BODY;
        end
      end
      default: begin
        p   = byte_pos;
        len = frame_len;
        if (p == 2) sender_q = b;
        if (p == 3) message_q = b;
        if (p + MsgTailLen + 1 <= len) begin
          fsum_a = fsum_a + b;
          fsum_b = fsum_b + fsum_a;
          if (p >= MsgHeaderLen) r.is_payload = 1'b1;
        end else if (p + MsgTailLen == len) begin
          first_check = b;
        end else begin
          r.frame_end  = 1'b1;
          r.frame_good = (first_check == fsum_a) && (b == fsum_b);
          hunt_phase   = PH_HUNT;
        end
        byte_pos = 8'(p + 1);
      end
    endcase
    r.sender_id  = sender_q;
    r.message_id = message_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      hunt_phase   = PH_HUNT;
      start_val    = StartByteReset;
      frame_len    = '0;
      byte_pos     = '0;
      fsum_a       = '0;
      fsum_b       = '0;
      first_check  = '0;
      sender_q     = '0;
      message_q    = '0;
      deframed_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0h",
                   $time, res_mon.data_byte);
          fail_count_o++;
        end else begin
          want = deframed_q.pop_front();
          check_field("data_byte", want.data_byte, res_mon.data_byte);
          check_field("is_payload", ByteW'(want.is_payload), ByteW'(res_mon.is_payload));
          check_field("frame_end", ByteW'(want.frame_end), ByteW'(res_mon.frame_end));
          check_field("frame_good", ByteW'(want.frame_good), ByteW'(res_mon.frame_good));
          check_field("sender_id", want.sender_id, res_mon.sender_id);
          check_field("message_id", want.message_id, res_mon.message_id);
        end
      end
      if (cfg_we_i) start_val = cfg_wdata_i;
      if (byte_mon.valid && byte_mon.ready) begin
        deframed_q.push_back(deframe_byte(byte_mon.rx_byte));
      end
      pending_o = deframed_q.size();
    end
  end

endmodule

### tb/tb_top.sv
// testbench top: drives byte frames and the start byte register, gives the verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LongStall = 300;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we;
  logic [tfc_pkg::ByteW-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_idle_pct = 9;
  int unsigned sink_idle_pct = 62;
  int unsigned bytes_sent = 0;
  int unsigned stall_requests = 0;
  int unsigned stalls_served = 0;
  logic [7:0]  cur_start = tfc_pkg::StartByteReset;

  tfc_byte_if   byte_ch ();
  tfc_result_if res_ch ();

  telemetry_frame_checker_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (byte_ch),
    .out_o       (res_ch)
  );

  tfc_frame_scoreboard u_scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .byte_mon     (byte_ch),
    .res_mon      (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("telemetry_frame_checker_top test failed");
    $finish;
  end

  initial begin : sink_proc
    int unsigned hold;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_requests != stalls_served) begin
        stalls_served++;
        res_ch.ready <= 1'b0;
        for (hold = 0; hold < LongStall; hold++) @(negedge clk);
      end
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned len, input logic [7:0] sid,
                            input logic [7:0] mid, input int unsigned spoil_pos,
                            input bit start_in_body);
    logic [7:0]  fb [$];
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  b;
    int unsigned p;
    fb.push_back(cur_start);
    fb.push_back(len[7:0]);
    sa = len[7:0];
    sb = len[7:0];
    for (p = 2; p + tfc_pkg::MsgTailLen + 1 <= len; p++) begin
      if (p == 2) b = sid;
      else if (p == 3) b = mid;
      else if (start_in_body) b = cur_start;
      else b = 8'($urandom_range(255));
      sa = sa + b;
      sb = sb + sa;
      fb.push_back(b);
    end
    fb.push_back(sa);
    fb.push_back(sb);
    if (spoil_pos != 0 && spoil_pos < fb.size()) begin
      fb[spoil_pos] = fb[spoil_pos] ^ 8'($urandom_range(255, 1));
    end
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  function automatic int unsigned pick_len();
    return ($urandom_range(19) == 0) ? $urandom_range(255, 4) : $urandom_range(24, 4);
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    int unsigned len;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_frame(pick_len(), 8'($urandom_range(255)), 8'($urandom_range(255)), 0,
                   $urandom_range(9) == 0);
      end else if (r < 82) begin
        len = pick_len();
        send_frame(len, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   $urandom_range(len - 1, 1), 1'b0);
      end else if (r < 88) begin
        send_byte(cur_start);
        send_byte(8'($urandom_range(3)));
      end else begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_start = v;
    @(negedge clk);
  endtask

  initial begin
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: noise while hunting, minimal frames, short lengths, bad check, start byte in the body
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(4, 8'h00, 8'h00, 0, 1'b0);
    send_byte(cur_start);
    send_byte(8'h00);
    send_byte(cur_start);
    send_byte(8'h03);
    send_frame(5, 8'hFF, 8'h00, 4, 1'b0);
    send_frame(7, 8'h00, 8'hFF, 0, 1'b1);
    wait_drained();

    write_start(8'h00);
    run_random(380);
    wait_drained();

    src_idle_pct  = 62;
    sink_idle_pct = 9;
    write_start(8'hFF);
    run_random(380);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_start(8'($urandom_range(254, 1)));
    stall_requests++;
    run_random(40);
    run_random(340);
    wait_drained();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("telemetry_frame_checker_top test passed");
    end else begin
      $display("telemetry_frame_checker_top test failed");
    end
    $finish;
  end

endmodule
